/* hdl/iqps_pkg.sv */
package iqps_pkg;

    // Default sizes of the switch.
    localparam int PORTS_DEF = 256;
    localparam int DEPTH_DEF = 16;

    // Fixed field widths of the words on the channels.
    localparam int PORT_W  = 9;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 9;

    // Request codes as they arrive on the request channel.
    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_TICK = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req_kind;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PORT = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // A classified request as held in the queue between front and back.
    typedef struct packed {
        t_req_kind           kind;
        logic                port_ok;
        logic [PORT_W-1:0]   port;
        logic [PORT_W-1:0]   dest;
        logic [DATA_W-1:0]   payload;
    } t_cmd;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Control from the back end to the front end.
    typedef struct packed {
        logic pop;
        logic cleared;
    } t_back_ctl;

    // One result word.
    typedef struct packed {
        t_status              status;
        logic [DATA_W-1:0]    payload_out;
        logic [COUNT_W-1:0]   moved_count;
        logic [COUNT_W-1:0]   dropped_count;
        logic                 inputs_empty;
    } t_rsp;

endpackage

/* hdl/iqps_if.sv */
// Request channel.
interface iqps_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [iqps_pkg::PORT_W-1:0] in_port;
    logic [iqps_pkg::PORT_W-1:0] dest_port;
    logic [iqps_pkg::DATA_W-1:0] payload_in;

    modport source (output valid, output req_type, output in_port,
                    output dest_port, output payload_in, input ready);
    modport sink   (input valid, input req_type, input in_port,
                    input dest_port, input payload_in, output ready);
endinterface

// Result channel.
interface iqps_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [iqps_pkg::DATA_W-1:0]  payload_out;
    logic [iqps_pkg::COUNT_W-1:0] moved_count;
    logic [iqps_pkg::COUNT_W-1:0] dropped_count;
    logic                         inputs_empty;

    modport source (output valid, output status, output payload_out,
                    output moved_count, output dropped_count,
                    output inputs_empty, input ready);
    modport sink   (input valid, input status, input payload_out,
                    input moved_count, input dropped_count,
                    input inputs_empty, output ready);
endinterface

/* hdl/iqps_ram.sv */
module iqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/iqps_front.sv */
module iqps_front #(
    parameter int PORTS = iqps_pkg::PORTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    iqps_req_if.sink            i_req,
    input  iqps_pkg::t_back_ctl i_ctl,
    output iqps_pkg::t_q_head   o_head
);
    import iqps_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    // Classify the incoming word: decode the request and check its port.
    always_comb begin
        w_cmd.kind    = t_req_kind'(i_req.req_type);
        w_cmd.port_ok = (i_req.in_port < PORT_W'(PORTS));
        w_cmd.port    = i_req.in_port;
        w_cmd.dest    = i_req.dest_port;
        w_cmd.payload = i_req.payload_in;
    end

    assign i_req.ready = (r_cnt != 2'd2) && i_ctl.cleared;
    assign w_push      = i_req.valid && i_req.ready;

    // Two-entry queue between the front and the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wptr] <= w_cmd;
                r_wptr      <= ~r_wptr;
            end
            if (i_ctl.pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_ctl.pop);
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rptr];

endmodule

/* hdl/iqps_back.sv */
module iqps_back #(
    parameter int PORTS = iqps_pkg::PORTS_DEF,
    parameter int DEPTH = iqps_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iqps_pkg::t_q_head   i_head,
    output iqps_pkg::t_back_ctl o_ctl,
    iqps_rsp_if.source          o_rsp
);
    import iqps_pkg::*;

    localparam int PW   = $clog2(PORTS);
    localparam int SW   = $clog2(DEPTH);
    localparam int SW1  = SW + 1;
    localparam int FW   = $clog2(DEPTH + 1);
    localparam int MW   = SW + FW;
    localparam int SAW  = $clog2(PORTS * DEPTH);
    localparam int TW   = $clog2(PORTS * DEPTH + 1);
    localparam int EW   = PORT_W + DATA_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ_CHK,
        S_RD_CHK,
        S_RD_DATA,
        S_T_CHK,
        S_T_ENT,
        S_T_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_p, n_p;
    t_cmd               r_cmd, n_cmd;
    logic [PORT_W-1:0]  r_dest, n_dest;
    logic [DATA_W-1:0]  r_pay, n_pay;
    logic [COUNT_W-1:0] r_moved, n_moved;
    logic [COUNT_W-1:0] r_dropped, n_dropped;
    logic [TW-1:0]      r_total, n_total;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp, n_rsp;

    // Memory ports.
    logic            im_we, om_we, is_we, os_we;
    logic [PW-1:0]   im_waddr, im_raddr, om_waddr, om_raddr;
    logic [MW-1:0]   im_wdata, im_rdata, om_wdata, om_rdata;
    logic [SAW-1:0]  is_waddr, is_raddr, os_waddr, os_raddr;
    logic [EW-1:0]   is_wdata, is_rdata;
    logic [DATA_W-1:0] os_wdata, os_rdata;

    logic w_pop;

    // Slot address of one entry of one port's queue.
    function automatic logic [SAW-1:0] f_addr(input logic [PW-1:0] port,
                                              input logic [SW-1:0] slot);
        return SAW'(port) * SAW'(DEPTH) + SAW'(slot);
    endfunction

    // Tail slot: head plus fill, modulo the depth.
    function automatic logic [SW-1:0] f_tail(input logic [SW-1:0] head,
                                             input logic [FW-1:0] fill);
        logic [SW1-1:0] sum;
        sum = {1'b0, head} + SW1'(fill);
        if (sum >= SW1'(DEPTH)) begin
            sum = sum - SW1'(DEPTH);
        end
        return sum[SW-1:0];
    endfunction

    // Head slot after a pop.
    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] head);
        return (head == SW'(DEPTH - 1)) ? '0 : head + 1'b1;
    endfunction

    // Head and fill of each input queue.
    iqps_ram #(.WIDTH(MW), .DEPTH(PORTS)) u_in_meta (
        .i_clk(i_clk), .i_we(im_we), .i_waddr(im_waddr), .i_wdata(im_wdata),
        .i_raddr(im_raddr), .o_rdata(im_rdata)
    );

    // Head and fill of each output queue.
    iqps_ram #(.WIDTH(MW), .DEPTH(PORTS)) u_out_meta (
        .i_clk(i_clk), .i_we(om_we), .i_waddr(om_waddr), .i_wdata(om_wdata),
        .i_raddr(om_raddr), .o_rdata(om_rdata)
    );

    // Input queue entries: destination and payload.
    iqps_ram #(.WIDTH(EW), .DEPTH(PORTS * DEPTH)) u_in_store (
        .i_clk(i_clk), .i_we(is_we), .i_waddr(is_waddr), .i_wdata(is_wdata),
        .i_raddr(is_raddr), .o_rdata(is_rdata)
    );

    // Output queue entries: payload.
    iqps_ram #(.WIDTH(DATA_W), .DEPTH(PORTS * DEPTH)) u_out_store (
        .i_clk(i_clk), .i_we(os_we), .i_waddr(os_waddr), .i_wdata(os_wdata),
        .i_raddr(os_raddr), .o_rdata(os_rdata)
    );

    // Sequencer for the three requests.
    always_comb begin
        logic [SW-1:0]     head;
        logic [FW-1:0]     fill;
        logic [SW-1:0]     ohead;
        logic [FW-1:0]     ofill;
        logic [PORT_W-1:0] d;
        logic              finish;
        logic              next_port;

        head  = im_rdata[MW-1:FW];
        fill  = im_rdata[FW-1:0];
        ohead = om_rdata[MW-1:FW];
        ofill = om_rdata[FW-1:0];
        d     = is_rdata[EW-1:DATA_W];

        n_state     = r_state;
        n_p         = r_p;
        n_cmd       = r_cmd;
        n_dest      = r_dest;
        n_pay       = r_pay;
        n_moved     = r_moved;
        n_dropped   = r_dropped;
        n_total     = r_total;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_rsp       = r_rsp;
        finish      = 1'b0;
        next_port   = 1'b0;
        w_pop       = 1'b0;

        im_we = 1'b0; im_waddr = r_p; im_wdata = '0; im_raddr = '0;
        om_we = 1'b0; om_waddr = '0;  om_wdata = '0; om_raddr = '0;
        is_we = 1'b0; is_waddr = '0;  is_wdata = '0; is_raddr = '0;
        os_we = 1'b0; os_waddr = '0;  os_wdata = '0; os_raddr = '0;

        case (r_state)
            // Zero the head and fill of every queue after reset.
            S_CLEAR: begin
                im_we    = 1'b1;
                om_we    = 1'b1;
                im_waddr = r_p;
                om_waddr = r_p;
                if (r_p == PW'(PORTS - 1)) begin
                    n_p     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end

            // Take the next command once the result register is free.
            S_IDLE: begin
                if (i_head.valid && !r_rsp_valid) begin
                    w_pop     = 1'b1;
                    n_cmd     = i_head.cmd;
                    n_moved   = '0;
                    n_dropped = '0;
                    n_rsp     = '0;
                    case (i_head.cmd.kind)
                        REQ_ENQ: begin
                            if (!i_head.cmd.port_ok) begin
                                n_rsp.status = ST_BAD_PORT;
                                finish       = 1'b1;
                            end else begin
                                im_raddr = i_head.cmd.port[PW-1:0];
                                n_state  = S_ENQ_CHK;
                            end
                        end
                        REQ_TICK: begin
                            n_p      = '0;
                            im_raddr = '0;
                            n_state  = S_T_CHK;
                        end
                        REQ_READ: begin
                            if (!i_head.cmd.port_ok) begin
                                n_rsp.status = ST_BAD_PORT;
                                finish       = 1'b1;
                            end else begin
                                om_raddr = i_head.cmd.port[PW-1:0];
                                n_state  = S_RD_CHK;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            // Append to the input queue unless it is full.
            S_ENQ_CHK: begin
                if (fill == FW'(DEPTH)) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    is_we    = 1'b1;
                    is_waddr = f_addr(r_cmd.port[PW-1:0], f_tail(head, fill));
                    is_wdata = {r_cmd.dest, r_cmd.payload};
                    im_we    = 1'b1;
                    im_waddr = r_cmd.port[PW-1:0];
                    im_wdata = {head, fill + 1'b1};
                    n_total  = r_total + 1'b1;
                end
                finish  = 1'b1;
                n_state = S_IDLE;
            end

            // Pop the output queue unless it is empty.
            S_RD_CHK: begin
                if (ofill == '0) begin
                    n_rsp.status = ST_EMPTY;
                    finish       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    os_raddr = f_addr(r_cmd.port[PW-1:0], ohead);
                    om_we    = 1'b1;
                    om_waddr = r_cmd.port[PW-1:0];
                    om_wdata = {f_inc(ohead), ofill - 1'b1};
                    n_state  = S_RD_DATA;
                end
            end

            S_RD_DATA: begin
                n_rsp.payload_out = os_rdata;
                finish            = 1'b1;
                n_state           = S_IDLE;
            end

            // Tick: pop the head of the current input queue if there is one.
            S_T_CHK: begin
                if (fill == '0) begin
                    next_port = 1'b1;
                end else begin
                    is_raddr = f_addr(r_p, head);
                    im_we    = 1'b1;
                    im_waddr = r_p;
                    im_wdata = {f_inc(head), fill - 1'b1};
                    n_total  = r_total - 1'b1;
                    n_state  = S_T_ENT;
                end
            end

            // Tick: check the destination and look up its output queue.
            S_T_ENT: begin
                if (d >= PORT_W'(PORTS)) begin
                    n_dropped = r_dropped + 1'b1;
                    next_port = 1'b1;
                end else begin
                    om_raddr = d[PW-1:0];
                    n_dest   = d;
                    n_pay    = is_rdata[DATA_W-1:0];
                    n_state  = S_T_OUT;
                end
            end

            // Tick: append to the output queue or drop the word.
            S_T_OUT: begin
                if (ofill == FW'(DEPTH)) begin
                    n_dropped = r_dropped + 1'b1;
                end else begin
                    os_we    = 1'b1;
                    os_waddr = f_addr(r_dest[PW-1:0], f_tail(ohead, ofill));
                    os_wdata = r_pay;
                    om_we    = 1'b1;
                    om_waddr = r_dest[PW-1:0];
                    om_wdata = {ohead, ofill + 1'b1};
                    n_moved  = r_moved + 1'b1;
                end
                next_port = 1'b1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance the tick to the next input port, or end it.
        if (next_port) begin
            if (r_p == PW'(PORTS - 1)) begin
                n_rsp.moved_count   = n_moved;
                n_rsp.dropped_count = n_dropped;
                finish              = 1'b1;
                n_state             = S_IDLE;
            end else begin
                n_p      = r_p + 1'b1;
                im_raddr = r_p + 1'b1;
                n_state  = S_T_CHK;
            end
        end

        // Load the result register.
        if (finish) begin
            n_rsp.inputs_empty = (n_total == '0);
            n_rsp_valid        = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_p         <= '0;
            r_total     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p         <= n_p;
            r_total     <= n_total;
            r_rsp_valid <= n_rsp_valid;
        end
        r_cmd     <= n_cmd;
        r_dest    <= n_dest;
        r_pay     <= n_pay;
        r_moved   <= n_moved;
        r_dropped <= n_dropped;
        r_rsp     <= n_rsp;
    end

    assign o_ctl.pop     = w_pop;
    assign o_ctl.cleared = (r_state != S_CLEAR);

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.payload_out   = r_rsp.payload_out;
    assign o_rsp.moved_count   = r_rsp.moved_count;
    assign o_rsp.dropped_count = r_rsp.dropped_count;
    assign o_rsp.inputs_empty  = r_rsp.inputs_empty;

endmodule

/* hdl/input_queued_packet_switch_unit.sv */
// Packet switch with PORTS input queues and PORTS output queues, each DEPTH
// words deep, all held in single-port-write RAMs with a registered read.
// In the back end a request with a bad port finishes at once; an enqueue, or
// a read of an empty queue, checks the queue's head and fill and then ends;
// a read that pops a word checks them and then fetches the data. A tick walks
// every input port in order (only a meta read for an empty port, an entry
// read too for a head with a bad destination, and an output queue check as
// well for a head with a valid destination). After reset the block clears
// the queue pointers one port at a time and accepts no word until that is
// done. A two-entry command queue lets new requests arrive while the back end
// works, and the result register holds one finished word until it is taken.
module input_queued_packet_switch_unit #(
    parameter int PORTS = iqps_pkg::PORTS_DEF,
    parameter int DEPTH = iqps_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iqps_req_if.sink   i_req,
    iqps_rsp_if.source o_rsp
);
    import iqps_pkg::*;

    t_q_head   w_head;
    t_back_ctl w_ctl;

    iqps_front #(.PORTS(PORTS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    iqps_back #(.PORTS(PORTS), .DEPTH(DEPTH)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (w_head),
        .o_ctl  (w_ctl),
        .o_rsp  (o_rsp)
    );

endmodule

/* sim/input_queued_packet_switch_unit_check.sv */
// Watches both channels, keeps a shadow copy of the switch queues and
// compares every result word with the oldest predicted one.
module input_queued_packet_switch_unit_check #(
    parameter int PORTS = iqps_pkg::PORTS_DEF,
    parameter int DEPTH = iqps_pkg::DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    iqps_req_if     i_req,
    iqps_rsp_if     i_rsp,
    output int      o_fail_count,
    output int      o_pending
);
    import iqps_pkg::*;

    // Shadow queues of the switch.
    logic [PORT_W-1:0] in_dest_q [PORTS][$];
    logic [DATA_W-1:0] in_data_q [PORTS][$];
    logic [DATA_W-1:0] out_data_q[PORTS][$];
    int                held_inputs;
    t_rsp              expected_words[$];

    assign o_pending = expected_words.size();

    // Work out the result word of one accepted request word.
    function automatic t_rsp switch_result(t_req_kind kind, int port, int dest,
                                           logic [DATA_W-1:0] data);
        t_rsp              r;
        logic [PORT_W-1:0] d;
        logic [DATA_W-1:0] w;
        r = '0;
        r.status = ST_OK;
        case (kind)
            REQ_ENQ: begin
                if (port >= PORTS) r.status = ST_BAD_PORT;
                else if (in_data_q[port].size() >= DEPTH) r.status = ST_FULL;
                else begin
                    in_dest_q[port].push_back(PORT_W'(dest));
                    in_data_q[port].push_back(data);
                    held_inputs++;
                end
            end
            REQ_TICK: begin
                for (int p = 0; p < PORTS; p++) begin
                    if (in_data_q[p].size() != 0) begin
                        d = in_dest_q[p].pop_front();
                        w = in_data_q[p].pop_front();
                        held_inputs--;
                        if (d >= PORTS || out_data_q[d].size() >= DEPTH) begin
                            r.dropped_count++;
                        end else begin
                            out_data_q[d].push_back(w);
                            r.moved_count++;
                        end
                    end
                end
            end
            REQ_READ: begin
                if (port >= PORTS) r.status = ST_BAD_PORT;
                else if (out_data_q[port].size() == 0) r.status = ST_EMPTY;
                else r.payload_out = out_data_q[port].pop_front();
            end
            default: ;
        endcase
        r.inputs_empty = (held_inputs == 0);
        return r;
    endfunction

    // Predict on request words, compare on result words.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            held_inputs = 0;
        end else begin
            if (i_req.valid && i_req.ready)
                expected_words.push_back(switch_result(t_req_kind'(i_req.req_type),
                    int'(i_req.in_port), int'(i_req.dest_port), i_req.payload_in));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no prediction waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (i_rsp.status !== want.status ||
                        i_rsp.payload_out !== want.payload_out ||
                        i_rsp.moved_count !== want.moved_count ||
                        i_rsp.dropped_count !== want.dropped_count ||
                        i_rsp.inputs_empty !== want.inputs_empty) begin
                        if (i_rsp.status !== want.status)
                            $error("status: expected %0d, got %0d",
                                   want.status, i_rsp.status);
                        if (i_rsp.payload_out !== want.payload_out)
                            $error("payload_out: expected %h, got %h",
                                   want.payload_out, i_rsp.payload_out);
                        if (i_rsp.moved_count !== want.moved_count)
                            $error("moved_count: expected %0d, got %0d",
                                   want.moved_count, i_rsp.moved_count);
                        if (i_rsp.dropped_count !== want.dropped_count)
                            $error("dropped_count: expected %0d, got %0d",
                                   want.dropped_count, i_rsp.dropped_count);
                        if (i_rsp.inputs_empty !== want.inputs_empty)
                            $error("inputs_empty: expected %0d, got %0d",
                                   want.inputs_empty, i_rsp.inputs_empty);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* sim/input_queued_packet_switch_unit_test.sv */
// Drives request words into the switch, stalls the result side at random
// and gives the verdict from the checker's failure count.
module input_queued_packet_switch_unit_test;
    import iqps_pkg::*;

    localparam int PORTS      = PORTS_DEF;
    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   stimulus_done;
    bit   long_stalls;

    iqps_req_if req_ch ();
    iqps_rsp_if rsp_ch ();

    input_queued_packet_switch_unit #(.PORTS(PORTS), .DEPTH(DEPTH)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    input_queued_packet_switch_unit_check #(.PORTS(PORTS), .DEPTH(DEPTH)) checker_0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Send one request word and wait until it is taken. Valid stays high
    // into the next word when there is no gap.
    task automatic send_word(t_req_kind kind, int port, int dest, logic [31:0] data,
                             bit gaps = 1);
        int gap;
        gap = (gaps && long_stalls) ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.in_port    <= PORT_W'(port);
        req_ch.dest_port  <= PORT_W'(dest);
        req_ch.payload_in <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Ports are mostly a small busy set so queues fill, with some bad ones.
    function automatic int pick_port();
        int c;
        c = $urandom_range(0, 99);
        if (c < 70) return $urandom_range(0, 7);
        if (c < 85) return $urandom_range(0, PORTS - 1);
        return $urandom_range(0, 511);
    endfunction

    // Result side: with long stalls on, hold ready low for a random count before each word.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = long_stalls ? $urandom_range(0, 16) : 0;
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Watchdog on cycles without any accepted word.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else if (i_rst_n && (pending != 0 || !stimulus_done))
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("input_queued_packet_switch_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int c;
        long_stalls       = 1'b1;
        stimulus_done     = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_NONE;
        req_ch.in_port    = '0;
        req_ch.dest_port  = '0;
        req_ch.payload_in = '0;
        i_rst_n           = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: edges of the fields, bad ports and destination, an empty read and a full input queue.
        send_word(REQ_READ, 0, 0, 0);                       // read empty
        send_word(REQ_ENQ, 0, PORTS - 1, 32'hFFFF_FFFF);
        send_word(REQ_ENQ, PORTS - 1, 0, 32'h0);
        send_word(REQ_ENQ, 511, 0, 32'h1234_5678);          // bad input port
        send_word(REQ_ENQ, 1, 511, 32'hA5A5_5A5A);          // bad destination
        send_word(REQ_NONE, 511, 511, 32'hFFFF_FFFF);
        send_word(REQ_TICK, 0, 0, 0);
        send_word(REQ_READ, PORTS - 1, 0, 0);
        send_word(REQ_READ, 0, 0, 0);
        send_word(REQ_READ, 256, 0, 0);                     // bad read port
        for (int k = 0; k < DEPTH + 1; k++)                 // last one is full
            send_word(REQ_ENQ, 2, 3, $urandom(), 0);
        for (int k = 0; k < 3; k++) send_word(REQ_TICK, 0, 0, 0, 0);

        // Random part: well-formed traffic with some noise.
        for (int n = 0; n < 950; n++) begin
            if (n % 200 == 100) long_stalls = ~long_stalls;
            c = $urandom_range(0, 99);
            if (c < 55)
                send_word(REQ_ENQ, pick_port(), pick_port(), $urandom());
            else if (c < 65)
                send_word(REQ_TICK, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom());
            else if (c < 97)
                send_word(REQ_READ, pick_port(), $urandom_range(0, 511), $urandom());
            else
                send_word(REQ_NONE, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom());
        end
        req_ch.valid <= 1'b0;
        stimulus_done = 1'b1;
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("input_queued_packet_switch_unit: match");
        else
            $display("input_queued_packet_switch_unit: mismatch");
        $finish;
    end
endmodule
